/* rtl/nsms_pkg.sv */
package nsms_pkg;

	localparam int FRAME_PIXELS = 65536;
	localparam int ADDR_W       = $clog2(FRAME_PIXELS);
	localparam int LPTR_W       = ADDR_W + 1;
	localparam int MAX_DIM      = 4096;
	localparam int DIM_W        = 13;
	localparam int IDX_W        = 12;
	localparam int STEP_W       = 29;
	localparam int ACC_W        = 32;
	localparam int SRC_ADDR_W   = 25;
	localparam int PIX_W        = 32;
	localparam int PADDR_W      = 5;

	typedef enum logic [2:0] {
		REG_SRC_W   = 3'd0,
		REG_SRC_H   = 3'd1,
		REG_DST_W   = 3'd2,
		REG_DST_H   = 3'd3,
		REG_STEP_X  = 3'd4,
		REG_STEP_Y  = 3'd5,
		REG_BGRA    = 3'd6,
		REG_BIG_END = 3'd7
	} reg_idx_t;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_EMIT = 1'b1;

	typedef struct packed {
		logic [DIM_W-1:0]  src_w;
		logic [DIM_W-1:0]  src_h;
		logic [DIM_W-1:0]  dst_w;
		logic [DIM_W-1:0]  dst_h;
		logic [STEP_W-1:0] step_x;
		logic [STEP_W-1:0] step_y;
		logic              bgra;
		logic              big_end;
		logic              restart;
	} cfg_t;

	typedef struct packed {
		logic              valid;
		logic              emit;
		logic              we;
		logic              last;
		logic              in_range;
		logic [ADDR_W-1:0] idx;
		logic [PIX_W-1:0]  data;
	} mem_req_t;

	typedef struct packed {
		logic             valid;
		logic             last;
		logic [PIX_W-1:0] pixel;
	} rd_rsp_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0)
			r = DIM_W'(1);
		else if (v > DIM_W'(MAX_DIM))
			r = DIM_W'(MAX_DIM);
		else
			r = v;
		return r;
	endfunction

	function automatic logic [PIX_W-1:0] swizzle(input logic [PIX_W-1:0] p, input logic bgra,
			input logic big_end);
		logic [PIX_W-1:0] r;
		case ({bgra, big_end})
			2'b10:   r = p;
			2'b11:   r = {p[7:0], p[15:8], p[23:16], p[31:24]};
			2'b01:   r = {p[23:0], p[31:24]};
			2'b00:   r = {p[31:24], p[7:0], p[15:8], p[23:16]};
			default: r = p;
		endcase
		return r;
	endfunction

endpackage

/* rtl/nsms_cfg.sv */
module nsms_cfg
	import nsms_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output cfg_t               cfg
);

	logic     wr;
	reg_idx_t idx;

	logic [DIM_W-1:0]  src_w_q, src_h_q, dst_w_q, dst_h_q;
	logic [STEP_W-1:0] step_x_q, step_y_q;
	logic              bgra_q, big_end_q, restart_q;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q   <= DIM_W'(256);
			src_h_q   <= DIM_W'(256);
			dst_w_q   <= DIM_W'(256);
			dst_h_q   <= DIM_W'(256);
			step_x_q  <= STEP_W'(32'h0001_0000);
			step_y_q  <= STEP_W'(32'h0001_0000);
			bgra_q    <= 1'b0;
			big_end_q <= 1'b0;
			restart_q <= 1'b0;
		end else begin
			// Any geometry write restarts the output scan on the next cycle.
			restart_q <= wr && (idx != REG_BGRA) && (idx != REG_BIG_END);
			if (wr) begin
				case (idx)
					REG_SRC_W:   src_w_q   <= pwdata[DIM_W-1:0];
					REG_SRC_H:   src_h_q   <= pwdata[DIM_W-1:0];
					REG_DST_W:   dst_w_q   <= pwdata[DIM_W-1:0];
					REG_DST_H:   dst_h_q   <= pwdata[DIM_W-1:0];
					REG_STEP_X:  step_x_q  <= pwdata[STEP_W-1:0];
					REG_STEP_Y:  step_y_q  <= pwdata[STEP_W-1:0];
					REG_BGRA:    bgra_q    <= pwdata[0];
					REG_BIG_END: big_end_q <= pwdata[0];
					default:     ;
				endcase
			end
		end
	end

	always_comb begin
		case (idx)
			REG_SRC_W:   prdata = 32'(src_w_q);
			REG_SRC_H:   prdata = 32'(src_h_q);
			REG_DST_W:   prdata = 32'(dst_w_q);
			REG_DST_H:   prdata = 32'(dst_h_q);
			REG_STEP_X:  prdata = 32'(step_x_q);
			REG_STEP_Y:  prdata = 32'(step_y_q);
			REG_BGRA:    prdata = 32'(bgra_q);
			REG_BIG_END: prdata = 32'(big_end_q);
			default:     prdata = '0;
		endcase
	end

	assign cfg = '{src_w: src_w_q, src_h: src_h_q, dst_w: dst_w_q, dst_h: dst_h_q,
		step_x: step_x_q, step_y: step_y_q, bgra: bgra_q, big_end: big_end_q,
		restart: restart_q};

endmodule

/* rtl/nsms_agen.sv */
module nsms_agen
	import nsms_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             adv,
	input  logic             accept,
	input  logic             cmd,
	input  logic [PIX_W-1:0] pixel,
	output mem_req_t         req_s3
);

	logic [LPTR_W-1:0] lptr_q;
	logic [IDX_W-1:0]  dest_col_q, dest_row_q;
	logic [ACC_W-1:0]  x_acc_q, y_acc_q;

	logic [DIM_W-1:0] sw, sh, dw, dh;
	logic [DIM_W-1:0] col_next, row_next;
	logic             col_wrap, row_wrap, last_c, load_ok;
	logic [ACC_W-1:0] half_x, half_y;

	assign sw = clamp_dim(cfg.src_w);
	assign sh = clamp_dim(cfg.src_h);
	assign dw = clamp_dim(cfg.dst_w);
	assign dh = clamp_dim(cfg.dst_h);

	assign half_x   = ACC_W'(cfg.step_x >> 1);
	assign half_y   = ACC_W'(cfg.step_y >> 1);
	assign col_next = {1'b0, dest_col_q} + DIM_W'(1);
	assign row_next = {1'b0, dest_row_q} + DIM_W'(1);
	assign col_wrap = col_next >= dw;
	assign row_wrap = row_next >= dh;
	assign last_c   = col_wrap && row_wrap;
	assign load_ok  = lptr_q < LPTR_W'(FRAME_PIXELS);

	// Scan state: advanced once per accepted request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lptr_q     <= '0;
			dest_col_q <= '0;
			dest_row_q <= '0;
			x_acc_q    <= ACC_W'(32'h0000_8000);
			y_acc_q    <= ACC_W'(32'h0000_8000);
		end else if (cfg.restart) begin
			dest_col_q <= '0;
			dest_row_q <= '0;
			x_acc_q    <= half_x;
			y_acc_q    <= half_y;
		end else if (accept) begin
			if (cmd == CMD_LOAD) begin
				if (load_ok)
					lptr_q <= lptr_q + LPTR_W'(1);
			end else if (!col_wrap) begin
				dest_col_q <= col_next[IDX_W-1:0];
				x_acc_q    <= x_acc_q + ACC_W'(cfg.step_x);
			end else begin
				dest_col_q <= '0;
				x_acc_q    <= half_x;
				if (row_wrap) begin
					dest_row_q <= '0;
					y_acc_q    <= half_y;
					lptr_q     <= '0;
				end else begin
					dest_row_q <= row_next[IDX_W-1:0];
					y_acc_q    <= y_acc_q + ACC_W'(cfg.step_y);
				end
			end
		end
	end

	// Stage 1: raw source coordinates or load address.
	logic              valid_s1, emit_s1, we_s1, last_s1;
	logic [ADDR_W-1:0] widx_s1;
	logic [PIX_W-1:0]  data_s1;
	logic [15:0]       xi_s1, yi_s1;

	// Stage 2: clamped and mirrored coordinates.
	logic              valid_s2, emit_s2, we_s2, last_s2;
	logic [ADDR_W-1:0] widx_s2;
	logic [PIX_W-1:0]  data_s2;
	logic [IDX_W-1:0]  col_s2, row_s2;

	// Stage 3: linear source address.
	logic              valid_s3, emit_s3, we_s3, last_s3;
	logic [ADDR_W-1:0] widx_s3;
	logic [PIX_W-1:0]  data_s3;
	logic [SRC_ADDR_W-1:0] saddr_s3;

	logic [DIM_W-1:0] swm1, shm1;
	logic [IDX_W-1:0] col_c, row_cl;
	logic [SRC_ADDR_W-1:0] saddr_c;

	assign swm1   = sw - DIM_W'(1);
	assign shm1   = sh - DIM_W'(1);
	assign col_c  = (xi_s1 > 16'(swm1)) ? swm1[IDX_W-1:0] : xi_s1[IDX_W-1:0];
	assign row_cl = (yi_s1 > 16'(shm1)) ? shm1[IDX_W-1:0] : yi_s1[IDX_W-1:0];
	assign saddr_c = SRC_ADDR_W'(row_s2) * SRC_ADDR_W'(sw) + SRC_ADDR_W'(col_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			emit_s1 <= (cmd == CMD_EMIT);
			we_s1   <= (cmd == CMD_LOAD) && load_ok;
			last_s1 <= (cmd == CMD_EMIT) && last_c;
			widx_s1 <= lptr_q[ADDR_W-1:0];
			data_s1 <= pixel;
			xi_s1   <= x_acc_q[ACC_W-1:16];
			yi_s1   <= y_acc_q[ACC_W-1:16];

			emit_s2 <= emit_s1;
			we_s2   <= we_s1;
			last_s2 <= last_s1;
			widx_s2 <= widx_s1;
			data_s2 <= data_s1;
			col_s2  <= col_c;
			row_s2  <= shm1[IDX_W-1:0] - row_cl;

			emit_s3  <= emit_s2;
			we_s3    <= we_s2;
			last_s3  <= last_s2;
			widx_s3  <= widx_s2;
			data_s3  <= data_s2;
			saddr_s3 <= saddr_c;
		end
	end

	assign req_s3 = '{valid: valid_s3, emit: emit_s3, we: we_s3, last: last_s3,
		in_range: (saddr_s3[SRC_ADDR_W-1:ADDR_W] == '0),
		idx: (emit_s3 ? saddr_s3[ADDR_W-1:0] : widx_s3), data: data_s3};

	a_lptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		lptr_q <= LPTR_W'(FRAME_PIXELS))
		else $error("load pointer ran past the frame store");

	a_no_write_on_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && emit_s3) |-> !we_s3)
		else $error("emit request carries a store write");

	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !cfg.restart && cmd == CMD_EMIT && last_c) |=>
		(dest_col_q == '0 && dest_row_q == '0 && lptr_q == '0))
		else $error("scan did not restart after the last pixel of the frame");

endmodule

/* rtl/nsms_store.sv */
module nsms_store
	import nsms_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     adv,
	input  mem_req_t req_s3,
	output rd_rsp_t  rsp_s4
);

	logic [PIX_W-1:0] mem [FRAME_PIXELS];
	logic [PIX_W-1:0] rd_s4;
	logic             valid_s4, last_s4, in_range_s4;

	// One access per request, in request order, so a load can never overtake an earlier read.
	always_ff @(posedge clk) begin
		if (adv && req_s3.valid) begin
			if (req_s3.we)
				mem[req_s3.idx] <= req_s3.data;
			rd_s4 <= mem[req_s3.idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s4 <= 1'b0;
		else if (adv)
			valid_s4 <= req_s3.valid && req_s3.emit;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s4     <= req_s3.last;
			in_range_s4 <= req_s3.in_range;
		end
	end

	assign rsp_s4 = '{valid: valid_s4, last: last_s4,
		pixel: (in_range_s4 ? rd_s4 : '0)};

endmodule

/* rtl/nearest_scale_mirror_swizzle_top.sv */
// Nearest-neighbour image scaler with vertical mirror and byte swizzle.
// Input stream (s_*): s_tuser is the command (0 load a source pixel, 1 emit
// the next destination pixel) and s_tdata the 32-bit source pixel for loads.
// Loads fill the frame store in raster order; loads beyond its 65536 pixels
// are dropped. Each emit request produces one output pixel on m_*, with
// m_tlast marking the final pixel of the destination frame, after which the
// scan and the load pointer start again for the next frame.
// Geometry, steps and pixel format are set over the APB port while the block
// is idle; a geometry write holds s_tready low for one cycle to restart the scan.
// The edge that accepts an emit request registers the request and its
// coordinates; then come clamp and mirror, the multiply to a linear address,
// the single-port store read and the swizzle output register, which drives
// m_tvalid. Throughput is one request per cycle while s_tready is high; loads
// and reads share the one store port in request order. When m_tready is low
// with a pixel waiting, the whole pipeline holds and s_tready falls. Reset
// clears the pipeline and the scan state and loads the default registers; the
// store contents are not cleared.
module nearest_scale_mirror_swizzle_top
	import nsms_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [31:0]        s_tdata,  // [31:0] pixel_in
	input  logic               s_tuser,  // [0] cmd
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [31:0]        m_tdata,  // [31:0] pixel_out
	output logic               m_tlast   // last_of_frame
);

	cfg_t     cfg;
	mem_req_t req_s3;
	rd_rsp_t  rsp_s4;
	logic     adv, accept;

	logic             out_valid_q, out_last_q;
	logic [PIX_W-1:0] out_data_q;

	assign adv      = !out_valid_q || m_tready;
	assign s_tready = adv && !cfg.restart;
	assign accept   = s_tvalid && s_tready;

	nsms_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	nsms_agen u_agen (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.adv    (adv),
		.accept (accept),
		.cmd    (s_tuser),
		.pixel  (s_tdata),
		.req_s3 (req_s3)
	);

	nsms_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.req_s3 (req_s3),
		.rsp_s4 (rsp_s4)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= rsp_s4.valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= swizzle(rsp_s4.pixel, cfg.bgra, cfg.big_end);
			out_last_q <= rsp_s4.last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule
